// ===== sv/rlrm_pkg.sv =====
// shared types and constants for the request latency and rate monitor
package rlrm_pkg;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  localparam int NWIN   = 5;
  localparam int NSAVED = 4;

  localparam logic [1:0] CFG_MINUTE = 2'd0;
  localparam logic [1:0] CFG_HOUR   = 2'd1;
  localparam logic [1:0] CFG_DAY    = 2'd2;

  localparam logic [15:0] MINUTE_RESET = 16'd60;
  localparam logic [23:0] HOUR_RESET   = 24'd3600;
  localparam logic [23:0] DAY_RESET    = 24'd86400;

  // classified operation passed from front to back
  typedef struct packed {
    func_t      func;
    logic [1:0] range;   // 0 short, 1 mid, 2 long
    logic [3:0] bucket;  // unclamped bucket inside range when below 16
    logic       big;     // bucket value at least 16
    logic       success;
    logic [5:0] read_index;
  } op_t;

endpackage

// ===== sv/rlrm_front.sv =====
// front end: accepts items and classifies latency into histogram ranges
module rlrm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     func,
  input  logic [31:0]    latency_ms,
  input  logic           success,
  input  logic [5:0]     read_index,
  output logic           op_valid,
  input  logic           op_ready,
  output rlrm_pkg::op_t  op
);

  // two entry queue
  rlrm_pkg::op_t q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  rlrm_pkg::op_t cls;
  logic [31:0] quot;
  logic        push;
  logic        pop;

  always_comb begin
    cls = '0;
    cls.func       = rlrm_pkg::func_t'(func);
    cls.success    = success;
    cls.read_index = read_index;
    if (latency_ms < 32'd100) begin
      cls.range = 2'd0;
      quot = ({25'd0, latency_ms[6:0]} * 32'd205) >> 11;
    end else if (latency_ms < 32'd1000) begin
      cls.range = 2'd1;
      quot = ({22'd0, latency_ms[9:0]} * 32'd1311) >> 17;
    end else begin
      cls.range = 2'd2;
      quot = (latency_ms < 32'd16000) ? (({18'd0, latency_ms[13:0]} * 32'd8389) >> 23)
                                      : 32'd16;
    end
    cls.big    = (quot >= 32'd16);
    cls.bucket = quot[3:0];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign op_valid = (count != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  a_full_ready: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !in_ready) else $error("ready while full");
  a_empty_valid: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !op_valid) else $error("valid while empty");
`endif

endmodule

// ===== sv/rlrm_back.sv =====
// back end: counters, windows, histogram and read result register
module rlrm_back #(
  parameter int HIST_BUCKETS = 10,
  parameter int COUNT_BITS   = 64,
  parameter int FLIGHT_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  rlrm_pkg::op_t op,
  input  logic [15:0]   minute_ticks,
  input  logic [23:0]   hour_ticks,
  input  logic [23:0]   day_ticks,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   read_data
);

  localparam int NB = 3 * HIST_BUCKETS;
  localparam int HW = $clog2(NB);
  localparam int NW = rlrm_pkg::NWIN;
  localparam int NS = rlrm_pkg::NSAVED;

  logic [COUNT_BITS-1:0]  hist [NB];
  logic [FLIGHT_BITS-1:0] in_flight;
  logic [COUNT_BITS-1:0]  live_total [NW];
  logic [COUNT_BITS-1:0]  live_success [NW];
  logic [FLIGHT_BITS-1:0] live_peak [NW];
  logic [COUNT_BITS-1:0]  saved_total [NS];
  logic [COUNT_BITS-1:0]  saved_success [NS];
  logic [FLIGHT_BITS-1:0] saved_peak [NS];
  logic [15:0] minute_tick_count;
  logic [23:0] hour_tick_count;
  logic [23:0] day_tick_count;

  logic        take;
  logic        is_end;
  logic        is_tick;
  logic [5:0]  bidx;
  logic [3:0]  bclamp;
  logic [15:0] min_next;
  logic [23:0] hour_next;
  logic [23:0] day_next;
  logic [NS-1:0] roll;
  logic [63:0] rd_value;
  logic [63:0] live_v;
  logic [63:0] saved_v;
  logic [5:0]  rel;
  logic [2:0]  win;
  logic [1:0]  fld;

  assign op_ready = !out_valid || out_ready;
  assign take     = op_valid && op_ready;
  assign is_end   = take && (op.func == rlrm_pkg::FUNC_END);
  assign is_tick  = take && (op.func == rlrm_pkg::FUNC_TICK);

  always_comb begin
    if (op.big || ({1'b0, op.bucket} > 5'(HIST_BUCKETS - 1))) begin
      bclamp = 4'(HIST_BUCKETS - 1);
    end else begin
      bclamp = op.bucket;
    end
    bidx = 6'(op.range * HIST_BUCKETS) + 6'(bclamp);
    min_next  = minute_tick_count + 16'd1;
    hour_next = hour_tick_count + 24'd1;
    day_next  = day_tick_count + 24'd1;
    roll[0] = 1'b1;
    roll[1] = (min_next >= minute_ticks);
    roll[2] = (hour_next >= hour_ticks);
    roll[3] = (day_next >= day_ticks);
  end

  // read select
  always_comb begin
    rd_value = '0;
    live_v   = '0;
    saved_v  = '0;
    rel      = op.read_index - 6'(NB + 1);
    // window and field of a window read, three fields per window
    if (rel >= 6'd12) begin
      win = 3'd4;
    end else if (rel >= 6'd9) begin
      win = 3'd3;
    end else if (rel >= 6'd6) begin
      win = 3'd2;
    end else if (rel >= 6'd3) begin
      win = 3'd1;
    end else begin
      win = 3'd0;
    end
    fld = 2'(rel - 6'({win, 1'b0}) - 6'(win));
    if (op.read_index < 6'(NB)) begin
      rd_value = 64'(hist[op.read_index[HW-1:0]]);
    end else if (op.read_index == 6'(NB)) begin
      rd_value = 64'(in_flight);
    end else if ({1'b0, op.read_index} < 7'(NB + 1 + 3 * NW)) begin
      case (fld)
        2'd0: live_v = 64'(live_total[win]);
        2'd1: live_v = 64'(live_success[win]);
        default: live_v = 64'(live_peak[win]);
      endcase
      if (win < 3'(NS)) begin
        case (fld)
          2'd0: saved_v = 64'(saved_total[win[1:0]]);
          2'd1: saved_v = 64'(saved_success[win[1:0]]);
          default: saved_v = 64'(saved_peak[win[1:0]]);
        endcase
      end
      rd_value = (live_v > saved_v) ? live_v : saved_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        hist[i] <= '0;
      end
      for (int w = 0; w < NW; w++) begin
        live_total[w]   <= '0;
        live_success[w] <= '0;
        live_peak[w]    <= '0;
      end
      for (int w = 0; w < NS; w++) begin
        saved_total[w]   <= '0;
        saved_success[w] <= '0;
        saved_peak[w]    <= '0;
      end
      in_flight         <= '0;
      minute_tick_count <= '0;
      hour_tick_count   <= '0;
      day_tick_count    <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (take && (op.func == rlrm_pkg::FUNC_READ)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        case (op.func)
          rlrm_pkg::FUNC_BEGIN: begin
            in_flight <= in_flight + 1'b1;
          end
          rlrm_pkg::FUNC_END: begin
            hist[bidx[HW-1:0]] <= hist[bidx[HW-1:0]] + 1'b1;
            for (int w = 0; w < NW; w++) begin
              live_total[w]   <= live_total[w] + 1'b1;
              live_success[w] <= live_success[w] + COUNT_BITS'(op.success);
              if (in_flight > live_peak[w]) begin
                live_peak[w] <= in_flight;
              end
            end
            if (in_flight != '0) begin
              in_flight <= in_flight - 1'b1;
            end
          end
          rlrm_pkg::FUNC_TICK: begin
            for (int w = 0; w < NS; w++) begin
              if (roll[w]) begin
                saved_total[w]   <= live_total[w];
                saved_success[w] <= live_success[w];
                saved_peak[w]    <= live_peak[w];
                live_total[w]    <= '0;
                live_success[w]  <= '0;
                live_peak[w]     <= in_flight;
              end
            end
            minute_tick_count <= roll[1] ? 16'd0 : min_next;
            hour_tick_count   <= roll[2] ? 24'd0 : hour_next;
            day_tick_count    <= roll[3] ? 24'd0 : day_next;
          end
          default: begin
            read_data <= rd_value;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (take && op.func == rlrm_pkg::FUNC_READ) |=> out_valid) else $error("read lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !op_ready) else $error("result overwritten");
  a_second_roll: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> (live_total[0] == '0)) else $error("second window not rolled");
`endif

endmodule

// ===== sv/request_latency_and_rate_monitor_top.sv =====
// Request latency and rate monitor. Takes one item per cycle sustained while the result side is
// ready: begin, end, tick or read, classified on entry into a two-entry queue and applied by the
// counter back end as it leaves the queue. A read loads its counter into the output register at
// the edge that takes it from the queue, so a result passes through the queue register and then
// the output register. A result held by the receiver stops the back end, and the input stalls once
// the queue holds two transactions. All counters clear at reset.
module request_latency_and_rate_monitor_top #(
  parameter int HIST_BUCKETS = 10,
  parameter int COUNT_BITS   = 64,
  parameter int FLIGHT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // latency_ms, success, read_index
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // read_data
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic          op_valid;
  logic          op_ready;
  rlrm_pkg::op_t op;
  logic [15:0]   minute_ticks;
  logic [23:0]   hour_ticks;
  logic [23:0]   day_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_ticks <= rlrm_pkg::MINUTE_RESET;
      hour_ticks   <= rlrm_pkg::HOUR_RESET;
      day_ticks    <= rlrm_pkg::DAY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rlrm_pkg::CFG_MINUTE: minute_ticks <= cfg_data[15:0];
        rlrm_pkg::CFG_HOUR:   hour_ticks   <= cfg_data;
        rlrm_pkg::CFG_DAY:    day_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  rlrm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .func       (s_axis_tuser),
    .latency_ms (s_axis_tdata[31:0]),
    .success    (s_axis_tdata[32]),
    .read_index (s_axis_tdata[38:33]),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op)
  );

  rlrm_back #(
    .HIST_BUCKETS (HIST_BUCKETS),
    .COUNT_BITS   (COUNT_BITS),
    .FLIGHT_BITS  (FLIGHT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op),
    .minute_ticks (minute_ticks),
    .hour_ticks   (hour_ticks),
    .day_ticks    (day_ticks),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .read_data    (m_axis_tdata)
  );

endmodule
